// ===== design/ohkt_pkg.sv =====
// Shared constants and types of the ordered hash keyed table.
package ohkt_pkg;

  localparam int DEF_TABLE_DEPTH = 64;
  localparam int DEF_VALUE_WIDTH = 32;
  localparam int DEF_TYPE_WIDTH  = 8;

  localparam int HASH_WIDTH     = 64;
  localparam int KEY_TYPE_WIDTH = 8;
  localparam int HANDLE_WIDTH   = 32;
  localparam int POS_WIDTH      = 6;
  localparam int NPOS_WIDTH     = 7;
  localparam int COUNT_WIDTH    = 7;

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DELETE = 2'd2,
    OP_READ   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_RANGE     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FETCH,
    S_DONE
  } state_t;

endpackage

// ===== design/ohkt_match.sv =====
// Key comparator: type tag and hash of one stored entry against the search key.
module ohkt_match import ohkt_pkg::*; #(
  parameter int TYPE_WIDTH = DEF_TYPE_WIDTH
) (
  input  logic [TYPE_WIDTH-1:0] key_type,
  input  logic [HASH_WIDTH-1:0] key_hash,
  input  logic [TYPE_WIDTH-1:0] entry_type,
  input  logic [HASH_WIDTH-1:0] entry_hash,
  output logic                  hit
);

  logic type_eq;
  logic hash_eq;

  assign type_eq = (entry_type == key_type);
  assign hash_eq = (entry_hash == key_hash);
  assign hit     = type_eq && hash_eq;

endmodule

// ===== design/ordered_hash_keyed_table_core.sv =====
// Insertion-ordered keyed table: entry memory, scan/shift sequencer and result register.
//
// The table keeps up to TABLE_DEPTH entries (type tag, hash, value handle) in one
// synchronous memory with a single read port and a single write port, and takes one
// item at a time. With n entries stored, a set, lookup or delete scans one entry per
// cycle: a miss gives its result once all n entries are scanned, and a hit on entry j
// is found once entry j is checked. A delete that hits entry j then moves the later
// entries down one per cycle before it gives its result. A read at position fetches
// that entry directly, with no scan. The single memory read port sets the pace of scan
// and shift. A finished result sits in the output register while the next beat is
// taken; while that register still holds a result not yet taken by out_ready, the next
// finished item waits in the sequencer. No clearing pass runs after reset: only entries
// below the fill count ever reach a result.
module ordered_hash_keyed_table_core import ohkt_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
  parameter int TYPE_WIDTH  = DEF_TYPE_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                opcode,
  input  logic [KEY_TYPE_WIDTH-1:0] key_type,
  input  logic [HASH_WIDTH-1:0]     key_hash,
  input  logic [HANDLE_WIDTH-1:0]   new_value,
  input  logic [HANDLE_WIDTH-1:0]   miss_value,
  input  logic                      use_default,
  input  logic [POS_WIDTH-1:0]      position,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                status,
  output logic [HANDLE_WIDTH-1:0]   value_out,
  output logic [POS_WIDTH-1:0]      entry_index,
  output logic [KEY_TYPE_WIDTH-1:0] out_key_type,
  output logic [HASH_WIDTH-1:0]     out_key_hash,
  output logic [NPOS_WIDTH-1:0]     next_position,
  output logic [COUNT_WIDTH-1:0]    entry_count
);

  localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int EW   = TYPE_WIDTH + HASH_WIDTH + VALUE_WIDTH;
  localparam int CMPW = (CW > POS_WIDTH) ? CW : POS_WIDTH;

  // entry memory
  logic [EW-1:0] mem [TABLE_DEPTH];
  logic [EW-1:0] rd_data;
  logic          mem_re;
  logic [AW-1:0] mem_ra;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [EW-1:0] mem_wd;

  logic [VALUE_WIDTH-1:0] rd_value;
  logic [HASH_WIDTH-1:0]  rd_hash;
  logic [TYPE_WIDTH-1:0]  rd_type;

  // control
  state_t        state;
  state_t        state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] scan_addr;
  logic          chk_valid;
  logic [AW-1:0] chk_idx;
  logic [CW-1:0] sh_addr;
  logic          sh_pend;
  logic [AW-1:0] sh_idx;

  // captured beat
  opcode_t                op_r;
  logic [TYPE_WIDTH-1:0]  ktype_r;
  logic [HASH_WIDTH-1:0]  khash_r;
  logic [VALUE_WIDTH-1:0] nval_r;
  logic [HANDLE_WIDTH-1:0] dflt_r;
  logic                   usedf_r;
  logic [POS_WIDTH-1:0]   pos_r;

  // result held until the output register is free
  status_t                 res_status;
  logic [HANDLE_WIDTH-1:0] res_value;
  logic [POS_WIDTH-1:0]    res_index;
  logic [KEY_TYPE_WIDTH-1:0] res_type;
  logic [HASH_WIDTH-1:0]   res_hash;
  logic [NPOS_WIDTH-1:0]   res_npos;

  logic in_fire;
  logic out_free;
  logic hit;
  logic scan_hit;
  logic scan_miss;
  logic shift_end;
  logic table_full;
  logic pos_ok;

  assign rd_value = rd_data[VALUE_WIDTH-1:0];
  assign rd_hash  = rd_data[VALUE_WIDTH +: HASH_WIDTH];
  assign rd_type  = rd_data[VALUE_WIDTH + HASH_WIDTH +: TYPE_WIDTH];

  ohkt_match #(
    .TYPE_WIDTH (TYPE_WIDTH)
  ) u_match (
    .key_type   (ktype_r),
    .key_hash   (khash_r),
    .entry_type (rd_type),
    .entry_hash (rd_hash),
    .hit        (hit)
  );

  assign in_fire    = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign scan_hit   = (state == S_SCAN) && chk_valid && hit;
  assign scan_miss  = (state == S_SCAN) && !chk_valid && (scan_addr >= count);
  assign shift_end  = (state == S_SHIFT) && !sh_pend && (sh_addr >= count);
  assign table_full = (count >= CW'(TABLE_DEPTH));
  assign pos_ok     = (CMPW'(pos_r) < CMPW'(count));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= mem[mem_ra];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (opcode_t'(opcode) == OP_READ) ? S_FETCH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          state_next = (op_r == OP_DELETE) ? S_SHIFT : S_DONE;
        end else if (scan_miss) begin
          state_next = S_DONE;
        end
      end
      S_SHIFT: begin
        if (shift_end) begin
          state_next = S_DONE;
        end
      end
      S_FETCH: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    mem_re   = 1'b0;
    mem_ra   = AW'(scan_addr);
    mem_we   = 1'b0;
    mem_wa   = chk_idx;
    mem_wd   = {ktype_r, khash_r, nval_r};
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        mem_re   = in_valid && (opcode_t'(opcode) == OP_READ);
        mem_ra   = AW'(position);
      end
      S_SCAN: begin
        mem_re = (scan_addr < count);
        if (scan_hit && op_r == OP_SET) begin
          mem_we = 1'b1;
        end else if (scan_miss && op_r == OP_SET && !table_full) begin
          mem_we = 1'b1;
          mem_wa = AW'(count);
        end
      end
      S_SHIFT: begin
        mem_re = (sh_addr < count);
        mem_ra = AW'(sh_addr);
        mem_we = sh_pend;
        mem_wa = sh_idx;
        mem_wd = rd_data;
      end
      S_FETCH, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (scan_miss && op_r == OP_SET && !table_full) begin
        count <= count + CW'(1);
      end else if (shift_end) begin
        count <= count - CW'(1);
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r       <= opcode_t'(opcode);
      ktype_r    <= TYPE_WIDTH'(key_type);
      khash_r    <= key_hash;
      nval_r     <= VALUE_WIDTH'(new_value);
      dflt_r     <= miss_value;
      usedf_r    <= use_default;
      pos_r      <= position;
      scan_addr  <= '0;
      chk_valid  <= 1'b0;
      res_status <= STAT_OK;
      res_value  <= '0;
      res_index  <= '0;
      res_type   <= '0;
      res_hash   <= '0;
      res_npos   <= '0;
    end
    if (state == S_SCAN) begin
      if (mem_re) begin
        scan_addr <= scan_addr + CW'(1);
      end
      chk_valid <= mem_re;
      chk_idx   <= AW'(scan_addr);
    end
    if (scan_hit) begin
      res_index <= POS_WIDTH'(chk_idx);
      if (op_r != OP_SET) begin
        res_value <= HANDLE_WIDTH'(rd_value);
      end
      sh_addr <= CW'(chk_idx) + CW'(1);
      sh_pend <= 1'b0;
    end
    if (scan_miss) begin
      if (op_r == OP_SET) begin
        if (table_full) begin
          res_status <= STAT_FULL;
        end else begin
          res_index <= POS_WIDTH'(count);
        end
      end else begin
        res_status <= STAT_NOT_FOUND;
        res_value  <= usedf_r ? dflt_r : '0;
      end
    end
    if (state == S_SHIFT) begin
      if (mem_re) begin
        sh_addr <= sh_addr + CW'(1);
      end
      sh_pend <= mem_re;
      sh_idx  <= AW'(sh_addr - CW'(1));
    end
    if (state == S_FETCH) begin
      if (pos_ok) begin
        res_value <= HANDLE_WIDTH'(rd_value);
        res_type  <= KEY_TYPE_WIDTH'(rd_type);
        res_hash  <= rd_hash;
        res_npos  <= NPOS_WIDTH'(pos_r) + NPOS_WIDTH'(1);
      end else begin
        res_status <= STAT_RANGE;
      end
    end
    if (state == S_DONE && out_free) begin
      status        <= res_status;
      value_out     <= res_value;
      entry_index   <= res_index;
      out_key_type  <= res_type;
      out_key_hash  <= res_hash;
      next_position <= res_npos;
      entry_count   <= COUNT_WIDTH'(count);
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state != S_IDLE)
    else $error("sequencer idle after taking a beat");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (CW'(mem_wa) <= count) && (CW'(mem_wa) < CW'(TABLE_DEPTH)))
    else $error("entry write beyond the filled region");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_FETCH || state == S_DONE) |=> $stable(count))
    else $error("fill count moved outside scan or shift");

  a_range_no_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_RANGE |-> next_position == '0)
    else $error("next position given on a bad position");
`endif

endmodule

// ===== bench/tb_ordered_hash_keyed_table_core.sv =====
// Ordered hash keyed table bench: directed rows, fill to capacity, random traffic, checked per beat.
module tb_ordered_hash_keyed_table_core;
  import ohkt_pkg::*;

  localparam int DEPTH          = DEF_TABLE_DEPTH;
  localparam int RANDOM_ITEMS   = 1260;
  localparam int BLOCK_ITEMS    = 140;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 200;

  typedef struct packed {
    logic [1:0]                op;
    logic [KEY_TYPE_WIDTH-1:0] kt;
    logic [HASH_WIDTH-1:0]     kh;
    logic [HANDLE_WIDTH-1:0]   nv;
    logic [HANDLE_WIDTH-1:0]   dv;
    logic                      ud;
    logic [POS_WIDTH-1:0]      pos;
  } cmd_t;

  typedef struct packed {
    logic [1:0]                st;
    logic [HANDLE_WIDTH-1:0]   val;
    logic [POS_WIDTH-1:0]      idx;
    logic [KEY_TYPE_WIDTH-1:0] kt;
    logic [HASH_WIDTH-1:0]     kh;
    logic [NPOS_WIDTH-1:0]     npos;
    logic [COUNT_WIDTH-1:0]    cnt;
  } result_t;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [1:0]                opcode = OP_SET;
  logic [KEY_TYPE_WIDTH-1:0] key_type = '0;
  logic [HASH_WIDTH-1:0]     key_hash = '0;
  logic [HANDLE_WIDTH-1:0]   new_value = '0;
  logic [HANDLE_WIDTH-1:0]   miss_value = '0;
  logic                      use_default = 1'b0;
  logic [POS_WIDTH-1:0]      position = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [1:0]                status;
  logic [HANDLE_WIDTH-1:0]   value_out;
  logic [POS_WIDTH-1:0]      entry_index;
  logic [KEY_TYPE_WIDTH-1:0] out_key_type;
  logic [HASH_WIDTH-1:0]     out_key_hash;
  logic [NPOS_WIDTH-1:0]     next_position;
  logic [COUNT_WIDTH-1:0]    entry_count;

  logic [KEY_TYPE_WIDTH-1:0] tab_type [DEPTH];
  logic [HASH_WIDTH-1:0]     tab_hash [DEPTH];
  logic [HANDLE_WIDTH-1:0]   tab_value [DEPTH];
  int                        tab_fill = 0;

  result_t expected_results [$];
  cmd_t    dir_cmds [$];
  bit      dir_typed [$];
  result_t dir_results [$];
  int      mismatch_count = 0;
  bit      no_idle = 1'b0;
  int      ready_hold = 0;

  ordered_hash_keyed_table_core i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .key_type(key_type),
    .key_hash(key_hash),
    .new_value(new_value),
    .miss_value(miss_value),
    .use_default(use_default),
    .position(position),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .value_out(value_out),
    .entry_index(entry_index),
    .out_key_type(out_key_type),
    .out_key_hash(out_key_hash),
    .next_position(next_position),
    .entry_count(entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic cmd_t mk_cmd(logic [1:0] op, logic [KEY_TYPE_WIDTH-1:0] kt,
                                  logic [HASH_WIDTH-1:0] kh, logic [HANDLE_WIDTH-1:0] nv,
                                  logic [HANDLE_WIDTH-1:0] dv, logic ud,
                                  logic [POS_WIDTH-1:0] pos);
    cmd_t c;
    c.op  = op;
    c.kt  = kt;
    c.kh  = kh;
    c.nv  = nv;
    c.dv  = dv;
    c.ud  = ud;
    c.pos = pos;
    return c;
  endfunction

  function automatic result_t mk_res(status_t st, logic [HANDLE_WIDTH-1:0] val,
                                     logic [POS_WIDTH-1:0] idx,
                                     logic [KEY_TYPE_WIDTH-1:0] kt,
                                     logic [HASH_WIDTH-1:0] kh,
                                     logic [NPOS_WIDTH-1:0] npos,
                                     logic [COUNT_WIDTH-1:0] cnt);
    result_t r;
    r.st   = st;
    r.val  = val;
    r.idx  = idx;
    r.kt   = kt;
    r.kh   = kh;
    r.npos = npos;
    r.cnt  = cnt;
    return r;
  endfunction

  // Apply one command to the shadow table and return the result it yields.
  function automatic result_t table_apply(cmd_t c);
    result_t r;
    int      hit;
    int      i;
    r   = '0;
    hit = -1;
    if (c.op != OP_READ) begin
      for (i = 0; i < tab_fill; i++) begin
        if (hit < 0 && tab_type[i] == c.kt && tab_hash[i] == c.kh) hit = i;
      end
    end
    case (c.op)
      OP_SET: begin
        if (hit >= 0) begin
          tab_value[hit] = c.nv;
          r.idx = hit[POS_WIDTH-1:0];
        end else if (tab_fill >= DEPTH) begin
          r.st = STAT_FULL;
        end else begin
          tab_type[tab_fill]  = c.kt;
          tab_hash[tab_fill]  = c.kh;
          tab_value[tab_fill] = c.nv;
          r.idx = tab_fill[POS_WIDTH-1:0];
          tab_fill++;
        end
      end
      OP_LOOKUP, OP_DELETE: begin
        if (hit < 0) begin
          r.st  = STAT_NOT_FOUND;
          r.val = c.ud ? c.dv : '0;
        end else begin
          r.val = tab_value[hit];
          r.idx = hit[POS_WIDTH-1:0];
          if (c.op == OP_DELETE) begin
            for (i = hit; i + 1 < tab_fill; i++) begin
              tab_type[i]  = tab_type[i+1];
              tab_hash[i]  = tab_hash[i+1];
              tab_value[i] = tab_value[i+1];
            end
            tab_fill--;
          end
        end
      end
      default: begin
        if (c.pos < tab_fill) begin
          r.val  = tab_value[c.pos];
          r.kt   = tab_type[c.pos];
          r.kh   = tab_hash[c.pos];
          r.npos = {1'b0, c.pos} + 7'd1;
        end else begin
          r.st = STAT_RANGE;
        end
      end
    endcase
    r.cnt = tab_fill[COUNT_WIDTH-1:0];
    return r;
  endfunction

  task automatic plan(input cmd_t c);
    dir_cmds.push_back(c);
    dir_typed.push_back(1'b0);
    dir_results.push_back('0);
  endtask

  task automatic plan_exp(input cmd_t c, input result_t r);
    dir_cmds.push_back(c);
    dir_typed.push_back(1'b1);
    dir_results.push_back(r);
  endtask

  // Offer one beat, hold it until taken, then book its expected result.
  task automatic send_item(input cmd_t c, input bit typed, input result_t r_typed);
    result_t r;
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    opcode        <= c.op;
    key_type      <= c.kt;
    key_hash      <= c.kh;
    new_value     <= c.nv;
    miss_value    <= c.dv;
    use_default   <= c.ud;
    position      <= c.pos;
    do @(posedge clk); while (!in_ready);
    r = table_apply(c);
    expected_results.push_back(typed ? r_typed : r);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic random_item(input bit growing);
    cmd_t c;
    int   roll;
    int   slot;
    roll = $urandom_range(0, 99);
    if (growing)
      c.op = roll < 55 ? OP_SET : roll < 70 ? OP_LOOKUP : roll < 80 ? OP_DELETE : OP_READ;
    else
      c.op = roll < 10 ? OP_SET : roll < 30 ? OP_LOOKUP : roll < 85 ? OP_DELETE : OP_READ;
    if (tab_fill > 0 && $urandom_range(0, 99) < (c.op == OP_SET ? 25 : 80)) begin
      slot = $urandom_range(0, tab_fill - 1);
      c.kt = tab_type[slot];
      c.kh = tab_hash[slot];
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) == 0) c.kh = c.kh ^ (64'd1 << $urandom_range(0, 63));
        else c.kt = c.kt ^ (8'd1 << $urandom_range(0, 7));
      end
    end else begin
      c.kt = KEY_TYPE_WIDTH'($urandom);
      c.kh = {$urandom, $urandom};
    end
    c.nv = $urandom;
    c.dv = $urandom;
    c.ud = 1'($urandom_range(0, 1));
    if (tab_fill > 0 && $urandom_range(0, 9) < 7)
      c.pos = POS_WIDTH'($urandom_range(0, tab_fill - 1));
    else c.pos = POS_WIDTH'($urandom_range(0, 63));
    send_item(c, 1'b0, '0);
  endtask

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!no_idle && $urandom_range(0, 2) == 0) begin
      out_ready  <= 1'b0;
      ready_hold <= $urandom_range(0, 14);
    end else begin
      out_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 19);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, status %0h value %0h", $time,
                 status, value_out);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", 64'(want.st), 64'(status));
        check_field("value_out", 64'(want.val), 64'(value_out));
        check_field("entry_index", 64'(want.idx), 64'(entry_index));
        check_field("out_key_type", 64'(want.kt), 64'(out_key_type));
        check_field("out_key_hash", want.kh, out_key_hash);
        check_field("next_position", 64'(want.npos), 64'(next_position));
        check_field("entry_count", 64'(want.cnt), 64'(entry_count));
      end
    end
  end

  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("[ordered_hash_keyed_table_core] ERROR");
    $finish;
  end

  initial begin
    int   n;
    cmd_t c;
    plan_exp(mk_cmd(OP_LOOKUP, 8'h00, 64'h0, 32'h0, 32'hFFFF_FFFF, 1'b1, 6'd0),
             mk_res(STAT_NOT_FOUND, 32'hFFFF_FFFF, 6'd0, 8'h00, 64'h0, 7'd0, 7'd0));
    plan_exp(mk_cmd(OP_DELETE, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 32'h1234_5678, 1'b0,
                    6'd0),
             mk_res(STAT_NOT_FOUND, 32'h0, 6'd0, 8'h00, 64'h0, 7'd0, 7'd0));
    plan_exp(mk_cmd(OP_READ, 8'h00, 64'h0, 32'h0, 32'h0, 1'b0, 6'd63),
             mk_res(STAT_RANGE, 32'h0, 6'd0, 8'h00, 64'h0, 7'd0, 7'd0));
    plan_exp(mk_cmd(OP_SET, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b0,
                    6'd0),
             mk_res(STAT_OK, 32'h0, 6'd0, 8'h00, 64'h0, 7'd0, 7'd1));
    plan(mk_cmd(OP_SET, 8'h00, 64'h0, 32'h0, 32'h0, 1'b0, 6'd0));
    plan(mk_cmd(OP_SET, 8'hFF, 64'h0, 32'h5A5A_5A5A, 32'h0, 1'b0, 6'd0));
    plan(mk_cmd(OP_SET, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 32'hA5A5_A5A5, 32'h0, 1'b0, 6'd0));
    plan_exp(mk_cmd(OP_LOOKUP, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 32'h0, 1'b1, 6'd0),
             mk_res(STAT_OK, 32'hFFFF_FFFF, 6'd0, 8'h00, 64'h0, 7'd0, 7'd4));
    plan(mk_cmd(OP_SET, 8'h00, 64'h0, 32'h1234_5678, 32'h0, 1'b0, 6'd0));
    plan(mk_cmd(OP_LOOKUP, 8'h00, 64'h0, 32'h0, 32'h0, 1'b0, 6'd0));
    plan(mk_cmd(OP_READ, 8'h00, 64'h0, 32'h0, 32'h0, 1'b0, 6'd3));
    plan_exp(mk_cmd(OP_READ, 8'h00, 64'h0, 32'h0, 32'h0, 1'b0, 6'd4),
             mk_res(STAT_RANGE, 32'h0, 6'd0, 8'h00, 64'h0, 7'd0, 7'd4));
    plan_exp(mk_cmd(OP_READ, 8'h00, 64'h0, 32'h0, 32'h0, 1'b0, 6'd63),
             mk_res(STAT_RANGE, 32'h0, 6'd0, 8'h00, 64'h0, 7'd0, 7'd4));
    plan_exp(mk_cmd(OP_LOOKUP, 8'h01, 64'h0, 32'h0, 32'hDEAD_BEEF, 1'b1, 6'd0),
             mk_res(STAT_NOT_FOUND, 32'hDEAD_BEEF, 6'd0, 8'h00, 64'h0, 7'd0, 7'd4));
    plan_exp(mk_cmd(OP_LOOKUP, 8'h00, 64'h8000_0000_0000_0000, 32'h0, 32'hFFFF_FFFF, 1'b0,
                    6'd0),
             mk_res(STAT_NOT_FOUND, 32'h0, 6'd0, 8'h00, 64'h0, 7'd0, 7'd4));
    plan(mk_cmd(OP_DELETE, 8'h00, 64'h0, 32'h0, 32'h0, 1'b0, 6'd0));
    plan(mk_cmd(OP_READ, 8'h00, 64'h0, 32'h0, 32'h0, 1'b0, 6'd1));
    plan(mk_cmd(OP_DELETE, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 32'h0, 1'b0, 6'd0));
    plan(mk_cmd(OP_DELETE, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 32'h0, 1'b0, 6'd0));
    plan_exp(mk_cmd(OP_DELETE, 8'h80, 64'h0, 32'h0, 32'h0F0F_0F0F, 1'b1, 6'd0),
             mk_res(STAT_NOT_FOUND, 32'h0F0F_0F0F, 6'd0, 8'h00, 64'h0, 7'd0, 7'd1));
    plan(mk_cmd(OP_READ, 8'h00, 64'h0, 32'h0, 32'h0, 1'b0, 6'd0));
    plan(mk_cmd(OP_DELETE, 8'hFF, 64'h0, 32'h0, 32'h0, 1'b0, 6'd0));
    plan_exp(mk_cmd(OP_READ, 8'h00, 64'h0, 32'h0, 32'h0, 1'b0, 6'd0),
             mk_res(STAT_RANGE, 32'h0, 6'd0, 8'h00, 64'h0, 7'd0, 7'd0));
    plan_exp(mk_cmd(OP_DELETE, 8'h00, 64'h0, 32'h0, 32'hFFFF_FFFF, 1'b1, 6'd0),
             mk_res(STAT_NOT_FOUND, 32'hFFFF_FFFF, 6'd0, 8'h00, 64'h0, 7'd0, 7'd0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_cmds[i]) send_item(dir_cmds[i], dir_typed[i], dir_results[i]);
    wait_for_results();

    // fill to capacity, then exercise the full table
    for (n = 0; n <= DEPTH; n++) begin
      c = mk_cmd(OP_SET, KEY_TYPE_WIDTH'($urandom), {$urandom, $urandom}, $urandom,
                 $urandom, 1'($urandom_range(0, 1)), POS_WIDTH'($urandom_range(0, 63)));
      send_item(c, 1'b0, '0);
    end
    send_item(mk_cmd(OP_READ, 8'h00, 64'h0, 32'h0, 32'h0, 1'b0, 6'd63), 1'b0, '0);
    c = mk_cmd(OP_SET, tab_type[10], tab_hash[10], $urandom, 32'h0, 1'b0, 6'd0);
    send_item(c, 1'b0, '0);
    c = mk_cmd(OP_DELETE, tab_type[DEPTH-1], tab_hash[DEPTH-1], 32'h0, 32'h0, 1'b0, 6'd0);
    send_item(c, 1'b0, '0);
    c = mk_cmd(OP_DELETE, tab_type[0], tab_hash[0], 32'h0, 32'h0, 1'b0, 6'd0);
    send_item(c, 1'b0, '0);
    for (n = 0; n < 3; n++) begin
      c = mk_cmd(OP_SET, KEY_TYPE_WIDTH'($urandom), {$urandom, $urandom}, $urandom, 32'h0,
                 1'b0, 6'd0);
      send_item(c, 1'b0, '0);
    end
    wait_for_results();

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n != 0 && n % BLOCK_ITEMS == 0) wait_for_results();
      if (n == RANDOM_ITEMS - BLOCK_ITEMS) no_idle = 1'b1;
      random_item((n / BLOCK_ITEMS) % 2 == 0);
    end
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[ordered_hash_keyed_table_core] OK");
    end else begin
      $display("[ordered_hash_keyed_table_core] ERROR");
    end
    $finish;
  end

endmodule
